// File: sv/fwpi_pkg.sv
// Shared types and codes for the positional-insert queue.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package fwpi_pkg;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_POP    = 2'd1,
		REQ_DRAIN  = 2'd2,
		REQ_INSERT = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_STORED  = 2'd0,
		ST_REMOVED = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	localparam logic [6:0] MAX_POS_RESET = 7'd16;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] value;
		logic signed [7:0]  position;
	} in_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [1:0]         status;
		logic               last;
	} out_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic last;
	} sts_t;

endpackage
`default_nettype wire

// File: sv/fwpi_ctrl.sv
// Sequencing controller for the positional-insert queue.
// Depends on fwpi_pkg for the command and status structs.
`default_nettype none
module fwpi_ctrl
	import fwpi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = S_RESP;
			end
			S_RESP: begin
				// A drain goes back for the next entry until its final transfer.
				if (!out_stall) begin
					state_nxt = sts.last ? S_IDLE : S_EXEC;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_RESP);

endmodule
`default_nettype wire

// File: sv/fwpi_dp.sv
// Datapath for the positional-insert queue: entry shift array, count,
// limit register, request latch and result register. Depends on fwpi_pkg.
`default_nettype none
module fwpi_dp
	import fwpi_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	input  wire in_t        in_data,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata,
	output out_t            out_data,
	output sts_t            sts
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]   entry_q [DEPTH];
	logic [CW-1:0] count_q;
	logic [6:0]    max_pos_q;
	in_t           req_q;
	out_t          res_q;

	logic          full, empty, is_pop, is_ins, pos_ok, do_ins, do_pop;
	logic [IW-1:0] p_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pos_q <= MAX_POS_RESET;
		end else if (cfg_we) begin
			max_pos_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
	end

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign is_pop = (req_q.req_type == REQ_POP) || (req_q.req_type == REQ_DRAIN);
	assign is_ins = (req_q.req_type == REQ_APPEND) || (req_q.req_type == REQ_INSERT);

	// An out-of-range insert, or one into an empty queue, lands at the tail.
	assign pos_ok = (req_q.req_type == REQ_INSERT) && !req_q.position[7] && !empty
		&& (req_q.position[6:0] <= max_pos_q)
		&& (8'(req_q.position) <= 8'(count_q));
	assign p_eff  = pos_ok ? IW'(req_q.position[6:0]) : IW'(count_q);
	assign do_ins = cmd.exec && is_ins && !full;
	assign do_pop = cmd.exec && is_pop && !empty;

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		localparam logic [IW-1:0] IDX_I = IW'(i);
		localparam logic [CW-1:0] IDX_C = CW'(i);
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (IDX_I == p_eff) begin
					entry_q[i] <= req_q.value;
				end else if (i > 0 && IDX_I > p_eff && IDX_C <= count_q) begin
					entry_q[i] <= entry_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_pop && i < DEPTH - 1) begin
				entry_q[i] <= entry_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + CW'(1);
		end else if (do_pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (cmd.exec) begin
			res_q.last <= !(req_q.req_type == REQ_DRAIN) || empty
				|| (count_q == CW'(1));
			if (is_ins) begin
				res_q.value_out <= '0;
				res_q.status    <= full ? ST_FULL : ST_STORED;
			end else if (empty) begin
				res_q.value_out <= '0;
				res_q.status    <= ST_EMPTY;
			end else begin
				res_q.status    <= ST_REMOVED;
				res_q.value_out <= entry_q[0];
			end
		end
	end

	assign out_data = res_q;
	assign sts.last = res_q.last;

endmodule
`default_nettype wire

// File: sv/fifo_with_positional_insert_unit.sv
// Positional-insert queue: each request goes through capture, execute and present result,
// and a new request is taken only once its last result has been accepted; a drain emits
// its results one by one through the execute/present loop of the controller.
// Reset clears the entry count, sets the position limit to 16 and drops out_valid;
// stored entries are not cleared. Depends on fwpi_pkg, fwpi_ctrl and fwpi_dp.
`default_nettype none
module fifo_with_positional_insert_unit
	import fwpi_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_t        in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_t            out_data,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	fwpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fwpi_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_data  (out_data),
		.sts       (sts)
	);

endmodule
`default_nettype wire
